/* design/convex_hull_graham_scan_assert.svh */
// Assertion macros used by the checker file.
`ifndef CONVEX_HULL_GRAHAM_SCAN_ASSERT_SVH
`define CONVEX_HULL_GRAHAM_SCAN_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define CHG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define CHG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* design/chg_pkg.sv */
package chg_pkg;
	typedef struct packed {
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic               final_point;
	} chg_in_t;

	typedef struct packed {
		logic signed [15:0] hx;
		logic signed [15:0] hy;
		logic               hull_last;
		logic               hull_empty;
		logic               dropped_points;
	} chg_out_t;

	// Operations the controller asks of the datapath in one cycle.
	localparam logic [3:0] OP_NONE     = 4'd0;
	localparam logic [3:0] OP_LOAD     = 4'd1;
	localparam logic [3:0] OP_PIV_RD   = 4'd2;
	localparam logic [3:0] OP_PIV_CMP  = 4'd3;
	localparam logic [3:0] OP_ORD_INIT = 4'd4;
	localparam logic [3:0] OP_SRT_RD   = 4'd5;
	localparam logic [3:0] OP_SRT_CMP  = 4'd6;
	localparam logic [3:0] OP_SCN_RD   = 4'd7;
	localparam logic [3:0] OP_SCN_CMP  = 4'd8;
	localparam logic [3:0] OP_EMIT_RD  = 4'd9;
	localparam logic [3:0] OP_SWP_RD   = 4'd10;

	typedef struct packed {
		logic [3:0] op;
		logic       clr;
	} chg_cmd_t;

	typedef struct packed {
		logic srt_less;
		logic scn_pop;
		logic piv_done;
		logic srt_row_done;
		logic srt_done;
		logic scn_done;
		logic emit_done;
		logic few;
	} chg_stat_t;
endpackage

/* design/chg_datapath.sv */
module chg_datapath import chg_pkg::*; #(
	parameter int MAX_POINTS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  chg_cmd_t  cmd,
	input  chg_in_t   in_word,
	output chg_stat_t stat,
	output chg_out_t  res_word
);
	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);

	// The points are sorted in place; the stack holds point words.
	logic [31:0]   pts [MAX_POINTS];
	logic [31:0]   stk [MAX_POINTS];

	logic [CW-1:0] cnt_q, n_q, i_q, j_q, sp_q;
	logic          ovf_q, drop_q;
	logic [AW-1:0] piv_q;
	logic [31:0]   pa_q, pb_q, pc_q, rd_q;
	logic [1:0]    ph_q;
	logic signed [33:0] p1_q, p2_q;
	logic signed [35:0] d1_q, d2_q;

	function automatic logic signed [16:0] sx(input logic [31:0] w);
		return {w[31], w[31:16]};
	endfunction
	function automatic logic signed [16:0] sy(input logic [31:0] w);
		return {w[15], w[15:0]};
	endfunction

	// Orientation operands: a,b,c. CCW when v < 0.
	logic signed [16:0] ab_y, bc_x, ab_x, bc_y;
	assign ab_y = sy(pb_q) - sy(pa_q);
	assign bc_x = sx(pc_q) - sx(pb_q);
	assign ab_x = sx(pb_q) - sx(pa_q);
	assign bc_y = sy(pc_q) - sy(pb_q);
	logic signed [16:0] da_x, da_y, db_x, db_y;
	assign da_x = sx(pb_q) - sx(pa_q);
	assign da_y = sy(pb_q) - sy(pa_q);
	assign db_x = sx(pc_q) - sx(pa_q);
	assign db_y = sy(pc_q) - sy(pa_q);
	logic signed [34:0] v;
	assign v = 35'(p1_q) - 35'(p2_q);
	logic signed [36:0] dd;
	assign dd = 37'(d1_q) - 37'(d2_q);

	logic piv_less;
	assign piv_less = (sy(rd_q) < sy(pa_q)) || (sy(rd_q) == sy(pa_q) && sx(rd_q) < sx(pa_q));

	always_comb begin
		stat = '0;
		stat.few = n_q < CW'(3);
		stat.piv_done = i_q >= n_q;
		stat.srt_done = i_q >= n_q;
		stat.srt_row_done = j_q <= CW'(1);
		stat.scn_done = i_q >= n_q;
		stat.emit_done = sp_q == '0;
		// The key sorts strictly before its neighbor around the pivot.
		stat.srt_less = (v < 0) || (v == 0 && dd < 0);
		// The first three points are pushed without a turn test.
		stat.scn_pop = (i_q >= CW'(3)) && (sp_q > CW'(1)) && !(v < 0);
	end

	always_comb begin
		res_word.hx = rd_q[31:16];
		res_word.hy = rd_q[15:0];
		res_word.hull_last = sp_q == '0;
		res_word.hull_empty = 1'b0;
		res_word.dropped_points = drop_q;
		if (n_q < CW'(3)) begin
			res_word.hx = '0;
			res_word.hy = '0;
			res_word.hull_last = 1'b1;
			res_word.hull_empty = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
			ph_q <= '0;
			n_q <= '0;
			drop_q <= 1'b0;
			piv_q <= '0;
			i_q <= '0;
			j_q <= '0;
			sp_q <= '0;
		end else begin
			ph_q <= (cmd.op == OP_SRT_CMP || cmd.op == OP_SCN_CMP) ? ph_q + 1'b1 : '0;
			unique case (cmd.op)
				OP_LOAD: begin
					if (cnt_q < CW'(MAX_POINTS)) cnt_q <= cnt_q + 1'b1;
					else ovf_q <= 1'b1;
					if (in_word.final_point) begin
						n_q <= (cnt_q < CW'(MAX_POINTS)) ? cnt_q + 1'b1 : cnt_q;
						drop_q <= ovf_q || !(cnt_q < CW'(MAX_POINTS));
						cnt_q <= '0;
						ovf_q <= 1'b0;
						piv_q <= '0;
						i_q <= CW'(1);
					end
				end
				OP_PIV_CMP: begin
					if (piv_less) piv_q <= i_q[AW-1:0];
					i_q <= i_q + 1'b1;
				end
				OP_ORD_INIT: begin
					i_q <= CW'(2);
					j_q <= CW'(2);
				end
				OP_SRT_RD: begin
					if (cmd.clr) j_q <= i_q;
				end
				OP_SRT_CMP: begin
					if (ph_q != 2'd0 && cmd.clr) begin
						// shift or place
						if (stat.srt_less && j_q > CW'(1)) j_q <= j_q - 1'b1;
						else i_q <= i_q + 1'b1;
					end
				end
				OP_SCN_RD: begin
					if (cmd.clr) begin
						sp_q <= '0;
						i_q <= '0;
					end
				end
				OP_SCN_CMP: begin
					if (ph_q != 2'd0 && cmd.clr) begin
						if (stat.scn_pop) sp_q <= sp_q - 1'b1;
						else begin
							sp_q <= sp_q + 1'b1;
							i_q <= i_q + 1'b1;
						end
					end
				end
				OP_EMIT_RD: begin
					if (n_q >= CW'(3)) sp_q <= sp_q - 1'b1;
					else sp_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Memories and the words read from them.
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				if (cnt_q < CW'(MAX_POINTS))
					pts[cnt_q[AW-1:0]] <= {in_word.px, in_word.py};
				if (cnt_q == '0) pa_q <= {in_word.px, in_word.py};
			end
			OP_PIV_RD: rd_q <= pts[i_q[AW-1:0]];
			OP_PIV_CMP: begin
				if (piv_less) pa_q <= rd_q;
			end
			OP_SWP_RD: begin
				// The pivot moves to slot 0; the old slot 0 word goes to its place next.
				rd_q <= pts[0];
				pts[0] <= pa_q;
			end
			OP_ORD_INIT: pts[piv_q] <= rd_q;
			OP_SRT_RD: begin
				if (cmd.clr) begin
					pb_q <= pts[i_q[AW-1:0]];
					pc_q <= pts[AW'(i_q - 1'b1)];
				end else begin
					pc_q <= pts[AW'(j_q - 1'b1)];
				end
			end
			OP_SRT_CMP: begin
				if (ph_q == 2'd0) begin
					p1_q <= ab_y * bc_x;
					p2_q <= ab_x * bc_y;
					d1_q <= da_x * da_x + da_y * da_y;
					d2_q <= db_x * db_x + db_y * db_y;
				end else if (cmd.clr) begin
					if (stat.srt_less && j_q > CW'(1)) pts[j_q[AW-1:0]] <= pc_q;
					else pts[j_q[AW-1:0]] <= pb_q;
				end
			end
			OP_SCN_RD: begin
				if (!cmd.clr) begin
					pa_q <= stk[AW'(sp_q - 2'd2)];
					pb_q <= stk[AW'(sp_q - 1'b1)];
					pc_q <= pts[i_q[AW-1:0]];
				end
			end
			OP_SCN_CMP: begin
				if (ph_q == 2'd0) begin
					p1_q <= ab_y * bc_x;
					p2_q <= ab_x * bc_y;
				end else if (cmd.clr && !stat.scn_pop) begin
					stk[sp_q[AW-1:0]] <= pc_q;
				end
			end
			OP_EMIT_RD: begin
				if (n_q >= CW'(3)) rd_q <= stk[AW'(sp_q - 1'b1)];
			end
			default: begin
			end
		endcase
	end
endmodule

/* design/chg_ctrl.sv */
module chg_ctrl import chg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_final,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  chg_stat_t stat,
	output chg_cmd_t  cmd
);
	localparam logic [3:0] S_LOAD = 4'd0, S_PRD = 4'd1, S_PCMP = 4'd2, S_OINIT = 4'd3,
		S_SRD = 4'd4, S_SCMP0 = 4'd5, S_SCMP1 = 4'd6, S_CRD = 4'd7, S_CCMP0 = 4'd8,
		S_CCMP1 = 4'd9, S_ERD = 4'd10, S_EOUT = 4'd11, S_SRD2 = 4'd12, S_CINIT = 4'd13,
		S_SWP = 4'd14;
	logic [3:0] state_q, nxt;

	assign in_ready = state_q == S_LOAD;
	assign out_valid = state_q == S_EOUT;

	always_comb begin
		nxt = state_q;
		cmd.op = OP_NONE;
		cmd.clr = 1'b0;
		unique case (state_q)
			S_LOAD: begin
				if (in_valid) begin
					cmd.op = OP_LOAD;
					if (in_final) nxt = S_PRD;
				end
			end
			S_PRD: begin
				if (stat.few) nxt = S_ERD;
				else if (stat.piv_done) nxt = S_SWP;
				else begin
					cmd.op = OP_PIV_RD;
					nxt = S_PCMP;
				end
			end
			S_PCMP: begin
				cmd.op = OP_PIV_CMP;
				nxt = S_PRD;
			end
			S_SWP: begin
				cmd.op = OP_SWP_RD;
				nxt = S_OINIT;
			end
			S_OINIT: begin
				cmd.op = OP_ORD_INIT;
				nxt = S_SRD;
			end
			S_SRD: begin
				if (stat.srt_done) nxt = S_CINIT;
				else begin
					cmd.op = OP_SRT_RD;
					cmd.clr = 1'b1;
					nxt = S_SCMP0;
				end
			end
			S_SRD2: begin
				cmd.op = OP_SRT_RD;
				nxt = S_SCMP0;
			end
			S_SCMP0: begin
				cmd.op = OP_SRT_CMP;
				nxt = S_SCMP1;
			end
			S_SCMP1: begin
				cmd.op = OP_SRT_CMP;
				cmd.clr = 1'b1;
				// keep shifting while key sorts before its neighbor and the row is not done
				if (stat.srt_less && !stat.srt_row_done) nxt = S_SRD2;
				else nxt = S_SRD;
			end
			S_CINIT: begin
				cmd.op = OP_SCN_RD;
				cmd.clr = 1'b1;
				nxt = S_CRD;
			end
			S_CRD: begin
				if (stat.scn_done) nxt = S_ERD;
				else begin
					cmd.op = OP_SCN_RD;
					nxt = S_CCMP0;
				end
			end
			S_CCMP0: begin
				cmd.op = OP_SCN_CMP;
				nxt = S_CCMP1;
			end
			S_CCMP1: begin
				cmd.op = OP_SCN_CMP;
				cmd.clr = 1'b1;
				nxt = S_CRD;
			end
			S_ERD: begin
				cmd.op = OP_EMIT_RD;
				nxt = S_EOUT;
			end
			S_EOUT: begin
				if (out_ready) nxt = stat.emit_done ? S_LOAD : S_ERD;
			end
			default: nxt = S_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= nxt;
		end
	end
endmodule

/* design/convex_hull_graham_scan.sv */
// After the final point the block finds the pivot, moves it to slot 0, sorts the points by angle
// around it and scans them into the hull stack; then it offers the hull words one at a time, top first.
// A set of fewer than three points skips these steps and answers with one empty hull word.
// Throughput: points load one per cycle; a set is processed fully before the next loads.
// The sort's compare loop through the single shared cross-product unit bounds the set rate.
// Reset (arst_n low) clears the controller, point count, counters and overflow flag.
module convex_hull_graham_scan import chg_pkg::*; #(
	parameter int MAX_POINTS = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  chg_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output chg_out_t out_data
);
	chg_cmd_t  cmd;
	chg_stat_t stat;

	chg_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_final(in_data.final_point),
		.in_ready(in_ready), .out_valid(out_valid), .out_ready(out_ready),
		.stat(stat), .cmd(cmd)
	);

	chg_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .in_word(in_data), .stat(stat),
		.res_word(out_data)
	);
endmodule

/* design/chg_checker.sv */
`include "convex_hull_graham_scan_assert.svh"
module chg_checker import chg_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     in_ready,
	input logic     out_valid,
	input logic     out_ready,
	input chg_out_t out_data
);
	// The block never takes a point while a result word waits.
	`CHG_ASSERT_IMP(a_no_overlap, clk, arst_n, out_valid, !in_ready, "in_ready during output")
	// An empty hull word always closes the set.
	`CHG_ASSERT_IMP(a_empty_last, clk, arst_n, out_valid && out_data.hull_empty,
		out_data.hull_last, "empty hull not marked last")
	// A word that is not taken stays on the port.
	`CHG_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data),
		"output changed while stalled")
	// After the last word the block returns to loading.
	`CHG_ASSERT_NEXT(a_back, clk, arst_n, out_valid && out_ready && out_data.hull_last,
		in_ready, "not ready after last word")
endmodule

bind convex_hull_graham_scan chg_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;
	import chg_pkg::*;

	localparam int CAP = 64;
	localparam int IDLE_LIMIT = 200000;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	chg_in_t  in_data;
	logic     out_valid;
	logic     out_ready;
	chg_out_t out_data;

	convex_hull_graham_scan #(.MAX_POINTS(CAP)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	// Predictor state for the set being collected.
	logic signed [15:0] set_x[CAP];
	logic signed [15:0] set_y[CAP];
	int                 set_count;
	bit                 set_overflow;

	chg_in_t  pending_points[$];
	chg_out_t expected_hull[$];
	int       error_count;
	int       words_sent, words_seen, sets_done;
	bit       stimulus_done, hold_sender, drain_wait, drain_used;
	int       stall_left;
	int       idle_cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint cross_sign(int a, int b, int c);
		longint v;
		v = (longint'(set_y[b]) - set_y[a]) * (longint'(set_x[c]) - set_x[b])
			- (longint'(set_x[b]) - set_x[a]) * (longint'(set_y[c]) - set_y[b]);
		return v;
	endfunction

	function automatic longint span2(int a, int b);
		longint dx, dy;
		dx = longint'(set_x[b]) - set_x[a];
		dy = longint'(set_y[b]) - set_y[a];
		return dx * dx + dy * dy;
	endfunction

	// Point a goes strictly ahead of point b around the pivot.
	function automatic bit goes_ahead(int p, int a, int b);
		longint v;
		v = cross_sign(p, a, b);
		if (v < 0) return 1'b1;
		if (v == 0) return span2(p, a) < span2(p, b);
		return 1'b0;
	endfunction

	task automatic expect_word(input chg_out_t w);
		expected_hull.insert(expected_hull.size(), w);
	endtask

	task automatic predict_hull(input chg_in_t pt);
		int n, piv, sp, j, key;
		bit drop;
		int order[CAP];
		int stack[CAP];
		chg_out_t w;
		if (set_count < CAP) begin
			set_x[set_count] = pt.px;
			set_y[set_count] = pt.py;
			set_count++;
		end else begin
			set_overflow = 1'b1;
		end
		if (!pt.final_point) return;
		n = set_count;
		drop = set_overflow;
		set_count = 0;
		set_overflow = 1'b0;
		sets_done++;
		if (n < 3) begin
			w = '0;
			w.hull_last = 1'b1;
			w.hull_empty = 1'b1;
			w.dropped_points = drop;
			expect_word(w);
			return;
		end
		piv = 0;
		for (int i = 1; i < n; i++)
			if (set_y[i] < set_y[piv] || (set_y[i] == set_y[piv] && set_x[i] < set_x[piv]))
				piv = i;
		for (int i = 0; i < n; i++) order[i] = i;
		order[0] = piv;
		order[piv] = 0;
		for (int i = 2; i < n; i++) begin
			key = order[i];
			j = i;
			while (j > 1 && goes_ahead(piv, key, order[j-1])) begin
				order[j] = order[j-1];
				j--;
			end
			order[j] = key;
		end
		stack[0] = order[0];
		stack[1] = order[1];
		stack[2] = order[2];
		sp = 3;
		for (int i = 3; i < n; i++) begin
			while (sp > 1 && cross_sign(stack[sp-2], stack[sp-1], order[i]) >= 0) sp--;
			stack[sp] = order[i];
			sp++;
		end
		for (int k = 0; k < sp; k++) begin
			w.hx = set_x[stack[sp-1-k]];
			w.hy = set_y[stack[sp-1-k]];
			w.hull_last = (k == sp - 1);
			w.hull_empty = 1'b0;
			w.dropped_points = drop;
			expect_word(w);
		end
	endtask

	function automatic chg_in_t make_point(int x, int y, bit last);
		chg_in_t p;
		p.px = x[15:0];
		p.py = y[15:0];
		p.final_point = last;
		return p;
	endfunction

	task automatic queue_point(int x, int y, bit last);
		pending_points.insert(pending_points.size(), make_point(x, y, last));
	endtask

	function automatic int rand_coord(int mode);
		case (mode)
			0: return $urandom_range(0, 65535) - 32768;
			1: return $urandom_range(0, 40) - 20;
			default: return ($urandom_range(0, 1) ? 32767 : -32768) - $urandom_range(0, 3)
				* ($urandom_range(0, 1) ? 1 : -1);
		endcase
	endfunction

	task automatic add_set(int n, int mode);
		for (int i = 0; i < n; i++)
			queue_point(rand_coord(mode), rand_coord(mode), i == n - 1);
	endtask

	initial begin
		int n;
		// Directed sets: tiny sets, a square with collinear and duplicate points,
		// extreme coordinates, all collinear, and one set beyond capacity.
		queue_point(5, 5, 1'b1);
		queue_point(1, 2, 1'b0);
		queue_point(3, 4, 1'b1);
		queue_point(0, 0, 1'b0);
		queue_point(4, 0, 1'b0);
		queue_point(2, 0, 1'b0);
		queue_point(4, 4, 1'b0);
		queue_point(2, 2, 1'b0);
		queue_point(4, 4, 1'b0);
		queue_point(0, 4, 1'b1);
		queue_point(32767, 32767, 1'b0);
		queue_point(-32768, 32767, 1'b0);
		queue_point(-32768, -32768, 1'b0);
		queue_point(32767, -32768, 1'b0);
		queue_point(0, 0, 1'b1);
		queue_point(1, 1, 1'b0);
		queue_point(2, 2, 1'b0);
		queue_point(3, 3, 1'b1);
		for (int i = 0; i < CAP + 3; i++)
			queue_point(rand_coord(1), rand_coord(1), i == CAP + 2);
		while (pending_points.size() < 330) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
			add_set(n, $urandom_range(0, 2));
		end
		stimulus_done = 1'b1;
	end

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Sender: bursts and gaps; pauses once mid-run until all hulls are back.
	int burst_left, gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			burst_left <= 0;
			gap_left <= 0;
			drain_wait = 1'b0;
			drain_used = 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				predict_hull(in_data);
				words_sent++;
				if (words_sent >= 200 && in_data.final_point && !drain_used) begin
					drain_wait = 1'b1;
					drain_used = 1'b1;
				end
			end
			if (drain_wait && expected_hull.size() == 0) drain_wait = 1'b0;
			if (!in_valid || in_ready) begin
				if (drain_wait) begin
					in_valid <= 1'b0;
				end else if (gap_left > 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending_points.size() != 0) begin
					in_valid <= 1'b1;
					in_data <= pending_points.pop_front();
					if (burst_left == 0) begin
						burst_left <= $urandom_range(1, 40);
					end else if (burst_left == 1) begin
						burst_left <= 0;
						gap_left <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: its own stall pattern plus one long hold-off early on.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
			hold_sender <= 1'b0;
		end else begin
			if (words_seen == 3 && stall_left == 0 && !hold_sender) begin
				hold_sender <= 1'b1;
				stall_left <= 400;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_ready <= (stall_left == 1);
			end else if (words_seen < 120 || words_seen > 240) begin
				out_ready <= ($urandom_range(0, 3) != 0);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		chg_out_t want;
		if (arst_n && out_valid && out_ready) begin
			words_seen++;
			if (expected_hull.size() == 0) begin
				$display("%0t: unexpected hull word %p", $time, out_data);
				error_count++;
			end else begin
				want = expected_hull.pop_front();
				if (out_data.hull_empty !== want.hull_empty
					|| out_data.hull_last !== want.hull_last
					|| out_data.dropped_points !== want.dropped_points
					|| (!want.hull_empty
						&& (out_data.hx !== want.hx || out_data.hy !== want.hy))) begin
					$display("%0t: hull word mismatch expected %p actual %p",
						$time, want, out_data);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no progress, %0d hull words outstanding", $time,
				expected_hull.size());
			$display("testbench NOT OK");
			$finish;
		end
	end

	initial begin
		wait (stimulus_done && arst_n);
		wait (pending_points.size() == 0 && !in_valid);
		wait (expected_hull.size() == 0);
		repeat (2000) @(posedge clk);
		$display("Sent %0d points in %0d sets; checked %0d hull words.",
			words_sent, sets_done, words_seen);
		if (error_count == 0 && expected_hull.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end
endmodule
